>>> sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg: shared definitions for the trial-division prime test
// Value width, derived datapath widths and the command and status bundles
// that connect the controller to the datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Width of the tested value and of the reply.
  localparam int VALUE_WIDTH = 32;

  // A divisor never exceeds the square root of the largest positive value
  // plus one, so half the width plus one bit is enough.
  localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;

  // Bit counter for the serial remainder unit.
  localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [DIV_WIDTH-1:0]   divisor_t;
  typedef logic [CNT_WIDTH-1:0]   bit_cnt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new candidate, restart at divisor two
    logic div_start;  // clear the remainder and point at the top bit
    logic div_step;   // process one bit of the remainder
    logic advance;    // move on to the next divisor
    logic out_load;   // capture the result into the output register
    logic prime;      // verdict that goes with out_load
  } tdpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;  // candidate is negative, zero or one
    logic sq_over;    // divisor squared exceeds the candidate
    logic div_last;   // the current remainder step is the last one
    logic rem_zero;   // the divisor divides the candidate evenly
  } tdpt_status_t;

endpackage

>>> sv/tdpt_if.sv
// ----------------------------------------------------------------------------
// tdpt_in_if / tdpt_out_if: ready/valid channels of the prime test
// The input channel carries a candidate; the output channel carries the
// prime flag and the reply value.
// ----------------------------------------------------------------------------
interface tdpt_in_if;
  import tdpt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if;
  import tdpt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          prime_flag;
  logic signed [VALUE_WIDTH-1:0] reply_value;

  modport source (output valid, output prime_flag, output reply_value, input ready);
  modport sink (input valid, input prime_flag, input reply_value, output ready);
endinterface

>>> sv/tdpt_dpath.sv
// ----------------------------------------------------------------------------
// tdpt_dpath: datapath of the prime test
// Holds the candidate, the running divisor and its square, a bit-serial
// remainder unit and the output register.
// ----------------------------------------------------------------------------
module tdpt_dpath (
  input  logic                   clk,
  input  tdpt_pkg::tdpt_cmd_t    cmd,
  input  tdpt_pkg::value_t       candidate,
  output tdpt_pkg::tdpt_status_t status,
  output logic                   prime_flag,
  output tdpt_pkg::value_t       reply_value
);
  import tdpt_pkg::*;

  localparam value_t   TWO_VALUE   = value_t'(2);
  localparam value_t   FOUR_VALUE  = value_t'(4);
  localparam divisor_t TWO_DIVISOR = divisor_t'(2);
  localparam bit_cnt_t TOP_BIT     = bit_cnt_t'(VALUE_WIDTH - 1);

  value_t   n_r, n_nxt;
  divisor_t d_r, d_nxt;
  value_t   sq_r, sq_nxt;
  divisor_t rem_r, rem_nxt;
  bit_cnt_t cnt_r, cnt_nxt;
  logic     prime_r;
  value_t   reply_r;

  logic [DIV_WIDTH:0] shifted;
  logic [DIV_WIDTH:0] d_ext;
  logic [DIV_WIDTH:0] odd_step;

  // One restoring step: bring in the next candidate bit, subtract if it fits.
  always_comb begin
    shifted = {rem_r, n_r[cnt_r]};
    d_ext   = {1'b0, d_r};
    if (shifted >= d_ext) begin
      rem_nxt = divisor_t'(shifted - d_ext);
    end else begin
      rem_nxt = shifted[DIV_WIDTH-1:0];
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
    end
  end

  // Divisor bookkeeping: (d + 1)^2 = d^2 + 2d + 1.
  always_comb begin
    odd_step = {d_r, 1'b1};
    n_nxt    = n_r;
    d_nxt    = d_r;
    sq_nxt   = sq_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      n_nxt  = candidate;
      d_nxt  = TWO_DIVISOR;
      sq_nxt = FOUR_VALUE;
    end else if (cmd.advance) begin
      d_nxt  = d_r + divisor_t'(1);
      sq_nxt = sq_r + value_t'(odd_step);
    end
    if (cmd.div_start) begin
      cnt_nxt = TOP_BIT;
    end else if (cmd.div_step) begin
      cnt_nxt = cnt_r - bit_cnt_t'(1);
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.div_start || cmd.div_step) begin
      rem_r <= rem_nxt;
    end
  end

  // Output register: the candidate when prime, all ones otherwise.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      prime_r <= cmd.prime;
      reply_r <= cmd.prime ? n_r : '1;
    end
  end

  assign status.below_two = n_r[VALUE_WIDTH-1] || (n_r < TWO_VALUE);
  assign status.sq_over   = sq_r > n_r;
  assign status.div_last  = cnt_r == '0;
  assign status.rem_zero  = rem_r == '0;

  assign prime_flag  = prime_r;
  assign reply_value = reply_r;

endmodule

>>> sv/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl: controller of the prime test
// Sequences the bound check, the serial remainder and the divisor step for
// each candidate, and manages the input and output handshakes.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  tdpt_pkg::tdpt_status_t status,
  output tdpt_pkg::tdpt_cmd_t    cmd
);
  import tdpt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_TEST   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   prime_r, prime_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    prime_nxt     = prime_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.prime     = prime_r;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.below_two) begin
          prime_nxt = 1'b0;
          state_nxt = ST_FINISH;
        end else if (status.sq_over) begin
          prime_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          prime_nxt = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prime_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prime_r     <= prime_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test of a signed value by trial division
// Top level joining the controller, the datapath and the two channels.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries one signed candidate; exactly
// one result transaction follows with the prime flag and the reply value (the
// candidate if it is prime, otherwise -1). Negative values, zero and one are
// not prime and finish without a search. Otherwise the divisors from 2 upward
// are tried while the divisor squared does not exceed the candidate; each
// divisor takes a bound check, one step per bit in the bit-serial remainder
// unit, and a test step. One candidate is processed at a time; the next one
// is accepted as soon as the previous result sits in the output register,
// even if it has not yet been taken.
module trial_division_prime_test (
  input logic       clk,
  input logic       rst_n,
  tdpt_in_if.sink   in_chan,
  tdpt_out_if.source out_chan
);
  import tdpt_pkg::*;

  tdpt_cmd_t    cmd;
  tdpt_status_t status;
  value_t       reply_value;

  // Sequencing and handshakes.
  tdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and result storage.
  tdpt_dpath u_dpath (
    .clk         (clk),
    .cmd         (cmd),
    .candidate   (value_t'(in_chan.candidate)),
    .status      (status),
    .prime_flag  (out_chan.prime_flag),
    .reply_value (reply_value)
  );

  assign out_chan.reply_value = $signed(reply_value);

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the trial-division prime test
// Drives signed candidates into the input channel and checks every result
// transaction against a trial-division predictor in the bench. Directed values
// cover the edges, and random values are shaped so that each test stays short.
// ----------------------------------------------------------------------------
module tb;
  import tdpt_pkg::*;

  // Generous run limit, enough for the largest prime.
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  // Cycles to wait after the last result for any stray transaction.
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic   prime_flag;
    value_t reply_value;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tdpt_in_if  cand_if ();
  tdpt_out_if verdict_if ();

  trial_division_prime_test DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (cand_if),
    .out_chan (verdict_if)
  );

  verdict_t    verdict_q[$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Clock generation.
  always #1 clk = ~clk;

  // Work out the expected verdict for one candidate by trial division.
  function automatic verdict_t predict_verdict(input value_t cand);
    longint unsigned n;
    longint unsigned d;
    verdict_t        v;
    n = 64'(cand);
    v.prime_flag  = 1'b0;
    v.reply_value = '1;
    // Negative values, zero and one are never prime.
    if (!cand[VALUE_WIDTH-1] && n >= 2) begin
      v.prime_flag = 1'b1;
      d = 2;
      while (v.prime_flag && d <= n / d) begin
        if (n % d == 0) v.prime_flag = 1'b0;
        d++;
      end
      if (v.prime_flag) v.reply_value = cand;
    end
    return v;
  endfunction

  // Result receiver that stalls at random.
  always @(posedge clk) begin
    verdict_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Record the expected verdict of every accepted candidate.
  always @(posedge clk) begin
    if (rst_n && cand_if.valid && cand_if.ready) begin
      verdict_q.push_back(predict_verdict(cand_if.candidate));
    end
  end

  // Compare each result transaction with the oldest expected verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && verdict_if.valid && verdict_if.ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: prime_flag %0b reply_value %0d",
               verdict_if.prime_flag, verdict_if.reply_value);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict_if.prime_flag !== want.prime_flag) begin
          $error("prime_flag: expected %0b, actual %0b",
                 want.prime_flag, verdict_if.prime_flag);
          mismatch_count++;
        end
        if (verdict_if.reply_value !== want.reply_value) begin
          $error("reply_value: expected %0d, actual %0d",
                 $signed(want.reply_value), verdict_if.reply_value);
          mismatch_count++;
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("trial_division_prime_test regression: fail");
      $finish;
    end
  end

  // Send one candidate, with a random gap before it, and wait for the transaction.
  task automatic send_candidate(input value_t cand);
    while ($urandom_range(99) < send_idle_pct) begin
      cand_if.valid <= 1'b0;
      @(posedge clk);
    end
    cand_if.valid     <= 1'b1;
    cand_if.candidate <= cand;
    do @(posedge clk); while (!cand_if.ready);
  endtask

  // Hold the input and wait until every expected result has arrived.
  task automatic wait_all_verdicts();
    cand_if.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Negative values, zero and one are rejected without a search.
  task automatic test_not_above_one();
    send_candidate(32'h8000_0000);
    send_candidate(32'hFFFF_FFFF);
    send_candidate(32'hAAAA_AAAA);
    send_candidate(32'h0000_0000);
    send_candidate(32'h0000_0001);
  endtask

  // Two and three need no divisor; squares of primes sit on the bound.
  task automatic test_small_values();
    send_candidate(32'd2);
    send_candidate(32'd3);
    send_candidate(32'd4);
    send_candidate(32'd5);
    send_candidate(32'd9);
    send_candidate(32'd25);
    send_candidate(32'd49);
    send_candidate(32'd97);
    send_candidate(32'd121);
    send_candidate(32'd169);
    send_candidate(32'd65521);
    send_candidate(32'd65537);
  endtask

  // Large positive values, then the largest one, which is a slow prime.
  task automatic test_extremes();
    send_candidate(32'h7FFF_FFFE);
    send_candidate(32'h5555_5555);
    send_candidate(32'h2AAA_AAAA);
    wait_all_verdicts();
    send_candidate(32'h7FFF_FFFF);
    wait_all_verdicts();
  endtask

  // Random candidates whose smallest factor or bound stays small.
  task automatic test_random_mix(input int send_pct, input int recv_pct, input int count);
    value_t cand;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2: cand = $urandom_range(1000);
        3, 4:    cand = $urandom_range(65535);
        5:       cand = $urandom_range(255, 2) * $urandom_range(65535, 2);
        6: begin
          cand = $urandom_range(255, 2);
          cand = cand * cand;
        end
        7:       cand = $urandom | 32'h8000_0000;
        8:       cand = $urandom & 32'h7FFF_FFFE;
        default: cand = 3 * $urandom_range(715_827_882);
      endcase
      send_candidate(cand);
    end
    wait_all_verdicts();
  endtask

  // Test sequence.
  initial begin
    cand_if.valid     = 1'b0;
    cand_if.candidate = '0;
    verdict_if.ready  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 60;
    test_not_above_one();
    test_small_values();
    test_extremes();

    test_random_mix(33, 60, 27);
    test_random_mix(60, 33, 26);
    test_random_mix(0, 0, 26);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("trial_division_prime_test regression: pass");
    end else begin
      $display("trial_division_prime_test regression: fail");
    end
    $finish;
  end

endmodule
